FILE: src/tcna_pkg.sv
// ----------------------------------------------------------------------------
// tcna_pkg
// Shared types and constants of the triangle centroid, normal and area unit.
// ----------------------------------------------------------------------------
package tcna_pkg;

    localparam int COORD_W   = 20;
    localparam int INDEX_W   = 12;
    localparam int UNIT_W    = 16;
    localparam int AREA_W    = 44;
    localparam int VERTEX_W  = 3 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int CROSS_W   = 43;
    localparam int MAG_W     = 42;
    localparam int SQ_W      = 84;
    localparam int QUOT_W    = 17;
    localparam int CNT_W     = 6;

    localparam int MUL_BITS  = MAG_W;
    localparam int SQRT_STEPS = 42;
    localparam int MUL_OPS   = 9;

    localparam logic       CMD_WRITE    = 1'b0;
    localparam logic       CMD_TRIANGLE = 1'b1;

    // Centroid: floor((s + 1) / 3) through a positive bias and a reciprocal
    localparam logic [31:0] CENT_BIAS = 32'd6291457;
    localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
    localparam logic [30:0] CENT_BACK = 31'd2097152;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_CENT,
        ST_MLOAD,
        ST_MUL,
        ST_MACC,
        ST_SQRT,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_DONE
    } state_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [CROSS_W-1:0] v);
        logic signed [CROSS_W-1:0] t;
        begin
            t = v[CROSS_W-1] ? -v : v;
            return t[MAG_W-1:0];
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] coord_of(input logic [VERTEX_W-1:0] raw,
                                                           input logic [1:0] k);
        logic signed [COORD_W-1:0] r;
        begin
            case (k)
                2'd0:    r = raw[VERTEX_W-1 -: COORD_W];
                2'd1:    r = raw[2*COORD_W-1 -: COORD_W];
                default: r = raw[COORD_W-1:0];
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/triangle_centroid_normal_area_unit.sv
// ----------------------------------------------------------------------------
// triangle_centroid_normal_area_unit
// Vertex store with triangle centroid, unit normal and area computation.
// ----------------------------------------------------------------------------
// A vertex write item (command 0) is taken in the idle state and gives no
// result; a write to a slot at or above VERTEX_COUNT is dropped. A triangle
// item (command 1) reads its three corners from the vertex RAM through its
// one read port, then runs one shared shift-add multiplier (one bit a cycle)
// for the six cross-product terms and three squares, a bit-pair square root
// and a restoring divider for the three normal components. The steps run in
// order: read, difference, centroid, multiply, root and divide, then hand
// over; the multiplier is the longest step. A degenerate triangle skips the
// divides. One item is worked on at a time; the finished result sits in an
// output register, so the next item is taken while it waits. A corner at or
// above VERTEX_COUNT reads as the zero vertex; a corner slot never written
// reads as anything.
// ----------------------------------------------------------------------------
module triangle_centroid_normal_area_unit
    import tcna_pkg::*;
#(
    parameter int VERTEX_COUNT = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [INDEX_W-1:0]         vertex_index,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    input  logic [INDEX_W-1:0]         corner_a,
    input  logic [INDEX_W-1:0]         corner_b,
    input  logic [INDEX_W-1:0]         corner_c,
    input  logic                       final_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  center_x,
    output logic signed [COORD_W-1:0]  center_y,
    output logic signed [COORD_W-1:0]  center_z,
    output logic signed [UNIT_W-1:0]   unit_x,
    output logic signed [UNIT_W-1:0]   unit_y,
    output logic signed [UNIT_W-1:0]   unit_z,
    output logic [AREA_W-1:0]          area,
    output logic                       degenerate,
    output logic                       final_result
);

    localparam int ADDR_W = $clog2(VERTEX_COUNT);

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       op_reg, op_next;
    logic             out_valid_reg, out_valid_next;
    logic             load_out;

    // item capture
    logic [ADDR_W-1:0]   addr_reg [0:2];
    logic [2:0]          ok_reg;
    logic                final_reg;
    logic [VERTEX_W-1:0] vert_reg [0:2];

    // datapath
    logic signed [DIFF_W-1:0]  a_reg [0:2];
    logic signed [DIFF_W-1:0]  b_reg [0:2];
    logic signed [COORD_W-1:0] cen_reg [0:2];
    logic signed [CROSS_W-1:0] c_reg [0:2];
    logic [SQ_W-1:0]           mc_reg;
    logic [MAG_W-1:0]          mp_reg;
    logic [SQ_W-1:0]           prod_reg;
    logic                      neg_reg;
    logic [SQ_W-1:0]           s_reg;
    logic [SQ_W-1:0]           sq_n_reg, sq_res_reg, sq_one_reg;
    logic [CROSS_W-1:0]        rem_reg;
    logic [QUOT_W-1:0]         num_reg, q_reg;
    logic signed [UNIT_W-1:0]  unit_reg [0:2];

    // output registers
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [UNIT_W-1:0]  ux_reg, uy_reg, uz_reg;
    logic [AREA_W-1:0]         area_reg;
    logic                      deg_reg, fin_reg;

    // RAM
    logic [31:0]         wr_idx_full;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VERTEX_W-1:0] rd_data;
    logic [1:0]          rd_sel;

    logic [31:0] ca_full, cb_full, cc_full;

    assign wr_idx_full = 32'(vertex_index);
    assign ca_full     = 32'(corner_a);
    assign cb_full     = 32'(corner_b);
    assign cc_full     = 32'(corner_c);

    assign wr_en = (state_reg == ST_IDLE) && in_valid && (command == CMD_WRITE)
                   && (wr_idx_full < 32'(VERTEX_COUNT));

    assign rd_addr = addr_reg[(cnt_reg[1:0] == 2'd3) ? 2'd2 : cnt_reg[1:0]];
    assign rd_sel  = cnt_reg[1:0] - 2'd1;

    tcna_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (VERTEX_COUNT)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_full[ADDR_W-1:0]),
        .wr_data ({coord_x, coord_y, coord_z}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // multiplier operand selection for the current op
    logic signed [CROSS_W-1:0] opl, opr;
    always_comb
    begin
        case (op_reg)
            4'd0:    begin opl = CROSS_W'(a_reg[1]); opr = CROSS_W'(b_reg[2]); end
            4'd1:    begin opl = CROSS_W'(a_reg[2]); opr = CROSS_W'(b_reg[1]); end
            4'd2:    begin opl = CROSS_W'(a_reg[2]); opr = CROSS_W'(b_reg[0]); end
            4'd3:    begin opl = CROSS_W'(a_reg[0]); opr = CROSS_W'(b_reg[2]); end
            4'd4:    begin opl = CROSS_W'(a_reg[0]); opr = CROSS_W'(b_reg[1]); end
            4'd5:    begin opl = CROSS_W'(a_reg[1]); opr = CROSS_W'(b_reg[0]); end
            4'd6:    begin opl = c_reg[0]; opr = c_reg[0]; end
            4'd7:    begin opl = c_reg[1]; opr = c_reg[1]; end
            default: begin opl = c_reg[2]; opr = c_reg[2]; end
        endcase
    end

    // signed cross term and running sum of squares
    logic signed [CROSS_W-1:0] term;
    logic [SQ_W-1:0]           s_sum;
    assign term  = neg_reg ? -$signed(prod_reg[CROSS_W-1:0]) : $signed(prod_reg[CROSS_W-1:0]);
    assign s_sum = s_reg + prod_reg;

    // centroid of the component picked by cnt
    logic signed [31:0] cent_sum;
    logic [31:0]        cent_t;
    logic [63:0]        cent_p;
    logic [30:0]        cent_q;
    assign cent_sum = 32'(coord_of(vert_reg[0], cnt_reg[1:0]))
                    + 32'(coord_of(vert_reg[1], cnt_reg[1:0]))
                    + 32'(coord_of(vert_reg[2], cnt_reg[1:0]));
    assign cent_t   = cent_sum + CENT_BIAS;
    assign cent_p   = 64'(cent_t) * 64'(RECIP3);
    assign cent_q   = cent_p[63:33] - CENT_BACK;

    // square root step
    logic [SQ_W:0] sq_try;
    logic          sq_take;
    assign sq_try  = {1'b0, sq_res_reg} + {1'b0, sq_one_reg};
    assign sq_take = {1'b0, sq_n_reg} >= sq_try;

    logic [MAG_W-1:0] len;
    assign len = sq_res_reg[MAG_W-1:0];

    // divider
    logic [MAG_W-1:0]   div_mag;
    logic [58:0]        div_num;
    logic [CROSS_W-1:0] div_den;
    logic [CROSS_W:0]   div_try;
    logic               div_take;
    assign div_mag  = mag_of(c_reg[op_reg[1:0]]);
    assign div_num  = {1'b0, div_mag, 16'd0} + 59'(len);
    assign div_den  = {len, 1'b0};
    assign div_try  = {rem_reg, num_reg[QUOT_W-1]};
    assign div_take = div_try >= {1'b0, div_den};

    // saturate and sign the quotient
    logic [QUOT_W-1:0] q_sat;
    logic [QUOT_W-1:0] q_neg;
    always_comb
    begin
        if (c_reg[op_reg[1:0]][CROSS_W-1])
        begin
            q_sat = (q_reg > 17'd32768) ? 17'd32768 : q_reg;
        end
        else
        begin
            q_sat = (q_reg > 17'd32767) ? 17'd32767 : q_reg;
        end
        q_neg = c_reg[op_reg[1:0]][CROSS_W-1] ? (17'd0 - q_sat) : q_sat;
    end

    // next state and handshake
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        load_out       = 1'b0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && command == CMD_TRIANGLE)
                begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_CENT;
                cnt_next   = '0;
            end
            ST_CENT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(2))
                begin
                    state_next = ST_MLOAD;
                    op_next    = '0;
                end
            end
            ST_MLOAD:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_BITS - 1))
                begin
                    state_next = ST_MACC;
                end
            end
            ST_MACC:
            begin
                if (op_reg == 4'(MUL_OPS - 1))
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_MLOAD;
                    op_next    = op_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DLOAD;
                    op_next    = '0;
                end
            end
            ST_DLOAD:
            begin
                cnt_next = '0;
                state_next = (len == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE:
            begin
                if (op_reg == 4'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DLOAD;
                    op_next    = op_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                // hold corner slots and their range checks
                addr_reg[0] <= ca_full[ADDR_W-1:0];
                addr_reg[1] <= cb_full[ADDR_W-1:0];
                addr_reg[2] <= cc_full[ADDR_W-1:0];
                ok_reg      <= {cc_full < 32'(VERTEX_COUNT),
                                cb_full < 32'(VERTEX_COUNT),
                                ca_full < 32'(VERTEX_COUNT)};
                final_reg   <= final_item;
            end
            ST_READ:
            begin
                if (cnt_reg != '0)
                begin
                    vert_reg[rd_sel] <= ok_reg[rd_sel] ? rd_data : '0;
                end
            end
            ST_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    a_reg[k] <= DIFF_W'(coord_of(vert_reg[1], 2'(k)))
                              - DIFF_W'(coord_of(vert_reg[0], 2'(k)));
                    b_reg[k] <= DIFF_W'(coord_of(vert_reg[2], 2'(k)))
                              - DIFF_W'(coord_of(vert_reg[0], 2'(k)));
                end
            end
            ST_CENT:
            begin
                cen_reg[cnt_reg[1:0]] <= cent_q[COORD_W-1:0];
            end
            ST_MLOAD:
            begin
                mc_reg   <= SQ_W'(mag_of(opl));
                mp_reg   <= mag_of(opr);
                prod_reg <= '0;
                neg_reg  <= opl[CROSS_W-1] ^ opr[CROSS_W-1];
            end
            ST_MUL:
            begin
                if (mp_reg[0])
                begin
                    prod_reg <= prod_reg + mc_reg;
                end
                mc_reg <= mc_reg << 1;
                mp_reg <= mp_reg >> 1;
            end
            ST_MACC:
            begin
                case (op_reg)
                    4'd0:    c_reg[0] <= term;
                    4'd1:    c_reg[0] <= c_reg[0] - term;
                    4'd2:    c_reg[1] <= term;
                    4'd3:    c_reg[1] <= c_reg[1] - term;
                    4'd4:    c_reg[2] <= term;
                    4'd5:    c_reg[2] <= c_reg[2] - term;
                    4'd6:    s_reg    <= prod_reg;
                    4'd7:    s_reg    <= s_sum;
                    default:
                    begin
                        sq_n_reg   <= s_sum;
                        sq_res_reg <= '0;
                        sq_one_reg <= SQ_W'(1) << (SQ_W - 2);
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (sq_take)
                begin
                    sq_n_reg   <= sq_n_reg - sq_try[SQ_W-1:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_one_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_one_reg <= sq_one_reg >> 2;
            end
            ST_DLOAD:
            begin
                rem_reg <= CROSS_W'(div_num[58:QUOT_W]);
                num_reg <= div_num[QUOT_W-1:0];
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                if (div_take)
                begin
                    rem_reg <= CROSS_W'(div_try - {1'b0, div_den});
                end
                else
                begin
                    rem_reg <= div_try[CROSS_W-1:0];
                end
                q_reg   <= {q_reg[QUOT_W-2:0], div_take};
                num_reg <= num_reg << 1;
            end
            ST_DSTORE:
            begin
                unit_reg[op_reg[1:0]] <= q_neg[UNIT_W-1:0];
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            cx_reg   <= cen_reg[0];
            cy_reg   <= cen_reg[1];
            cz_reg   <= cen_reg[2];
            deg_reg  <= (len == '0);
            ux_reg   <= (len == '0) ? '0 : unit_reg[0];
            uy_reg   <= (len == '0) ? '0 : unit_reg[1];
            uz_reg   <= (len == '0) ? '0 : unit_reg[2];
            area_reg <= AREA_W'(len >> 1);
            fin_reg  <= final_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign center_x     = cx_reg;
    assign center_y     = cy_reg;
    assign center_z     = cz_reg;
    assign unit_x       = ux_reg;
    assign unit_y       = uy_reg;
    assign unit_z       = uz_reg;
    assign area         = area_reg;
    assign degenerate   = deg_reg;
    assign final_result = fin_reg;

`ifndef NO_ASSERTIONS
    // a degenerate result carries a zero normal and zero area
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && deg_reg |-> ux_reg == '0 && uy_reg == '0 && uz_reg == '0
                                     && area_reg == '0)
        else $error("degenerate result with nonzero normal or area");

    // a proper triangle always has some nonzero normal component
    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !deg_reg |-> ux_reg != '0 || uy_reg != '0 || uz_reg != '0)
        else $error("nondegenerate result with zero normal");

    // a new result appears only from the hand-over state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside hand-over");

    // step counter stays within the longest loop, one past its last step
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MUL_BITS))
        else $error("step counter out of range");
`endif

endmodule

FILE: src/tcna_ram.sv
// ----------------------------------------------------------------------------
// tcna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcna_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the triangle centroid, normal and area unit against its own predictor.
// ----------------------------------------------------------------------------
// Vertex writes load a shadow copy of the store. Each accepted triangle item
// is turned into an expected centroid, Q1.15 unit normal, area and flags.
// These are matched in order against the results that come out. A short
// directed table runs first, then randomized vertex writes and triangles.
// Both sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb;
    import tcna_pkg::*;

    localparam int N_SLOTS       = 4096;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int QUIET_FROM    = 1800;
    localparam int DRAIN_AT      = 1000;
    localparam int TAIL_CYCLES   = 600;
    localparam int STUCK_LIMIT   = 20000;
    localparam int CENT_OFFSET   = 2097152;

    typedef struct {
        logic                       cmd;
        logic [INDEX_W-1:0]         slot;
        logic signed [COORD_W-1:0]  px, py, pz;
        logic [INDEX_W-1:0]         ca, cb, cc;
        logic                       fin;
    } mesh_item_t;

    typedef struct {
        logic signed [COORD_W-1:0]  cen_x, cen_y, cen_z;
        logic signed [UNIT_W-1:0]   nx, ny, nz;
        logic [AREA_W-1:0]          area;
        logic                       degen;
        logic                       fin;
    } geometry_t;

    typedef struct {
        mesh_item_t  it;
        bit          known;
        geometry_t   want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       command = CMD_WRITE;
    logic [INDEX_W-1:0]         vertex_index = '0;
    logic signed [COORD_W-1:0]  coord_x = '0;
    logic signed [COORD_W-1:0]  coord_y = '0;
    logic signed [COORD_W-1:0]  coord_z = '0;
    logic [INDEX_W-1:0]         corner_a = '0;
    logic [INDEX_W-1:0]         corner_b = '0;
    logic [INDEX_W-1:0]         corner_c = '0;
    logic                       final_item = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [COORD_W-1:0]  center_x, center_y, center_z;
    logic signed [UNIT_W-1:0]   unit_x, unit_y, unit_z;
    logic [AREA_W-1:0]          area;
    logic                       degenerate;
    logic                       final_result;

    // Shadow vertex store, plus the slots written so far; triangles only
    // ever name written slots, since unwritten ones read as anything.
    logic signed [COORD_W-1:0]  shadow_x [N_SLOTS];
    logic signed [COORD_W-1:0]  shadow_y [N_SLOTS];
    logic signed [COORD_W-1:0]  shadow_z [N_SLOTS];
    bit                         slot_written [N_SLOTS];
    int                         written_slots [$];

    geometry_t                  pending_geometry [$];
    stim_row_t                  directed_rows [$];

    int   mismatch_count = 0;
    int   write_count = 0;
    int   triangle_count = 0;
    int   degen_count = 0;
    int   result_count = 0;
    int   stuck_cycles = 0;
    int   stall_left = 0;
    bit   no_idle = 1'b0;
    logic next_stall;

    triangle_centroid_normal_area_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .unit_x       (unit_x),
        .unit_y       (unit_y),
        .unit_z       (unit_z),
        .area         (area),
        .degenerate   (degenerate),
        .final_result (final_result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: centroid, cross product, floor root, Q1.15 normal, area
    // ------------------------------------------------------------------------

    // Mean of three coordinates, rounded to nearest: floor((s + 1) / 3).
    // Bias to keep the division on positive numbers.
    function automatic logic signed [COORD_W-1:0] mean3(input longint s);
        longint q;
        begin
            q = (s + 1 + 3 * CENT_OFFSET) / 3 - CENT_OFFSET;
            return q[COORD_W-1:0];
        end
    endfunction

    // One normal component: |c| / len with ties away from zero, saturated.
    function automatic logic signed [UNIT_W-1:0] normal_comp(input longint c,
                                                             input logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        begin
            m = (c < 0) ? -c : c;
            q = ((m << 16) + len) / (2 * len);
            if (c < 0)
            begin
                if (q > 64'd32768)
                    q = 64'd32768;
                q = -q;
            end
            else if (q > 64'd32767)
            begin
                q = 64'd32767;
            end
            return q[UNIT_W-1:0];
        end
    endfunction

    function automatic geometry_t triangle_geometry(input mesh_item_t it);
        geometry_t   g;
        longint      vx [3];
        longint      vy [3];
        longint      vz [3];
        longint      ex, ey, ez, fx, fy, fz;
        longint      cr [3];
        logic [87:0] sq_sum;
        logic [87:0] mg;
        logic [87:0] trial;
        logic [63:0] len;
        logic [INDEX_W-1:0] idx [3];
        begin
            idx[0] = it.ca;
            idx[1] = it.cb;
            idx[2] = it.cc;
            for (int j = 0; j < 3; j++)
            begin
                vx[j] = shadow_x[idx[j]];
                vy[j] = shadow_y[idx[j]];
                vz[j] = shadow_z[idx[j]];
            end
            g.cen_x = mean3(vx[0] + vx[1] + vx[2]);
            g.cen_y = mean3(vy[0] + vy[1] + vy[2]);
            g.cen_z = mean3(vz[0] + vz[1] + vz[2]);
            ex = vx[1] - vx[0];
            ey = vy[1] - vy[0];
            ez = vz[1] - vz[0];
            fx = vx[2] - vx[0];
            fy = vy[2] - vy[0];
            fz = vz[2] - vz[0];
            cr[0] = ey * fz - ez * fy;
            cr[1] = ez * fx - ex * fz;
            cr[2] = ex * fy - ey * fx;
            sq_sum = '0;
            for (int k = 0; k < 3; k++)
            begin
                mg = (cr[k] < 0) ? 88'(-cr[k]) : 88'(cr[k]);
                sq_sum = sq_sum + mg * mg;
            end
            // Floor square root, one bit at a time from the top
            len = '0;
            for (int b = 41; b >= 0; b--)
            begin
                trial = 88'(len | (64'd1 << b));
                if (trial * trial <= sq_sum)
                    len = trial[63:0];
            end
            if (len == 0)
            begin
                g.nx = '0;
                g.ny = '0;
                g.nz = '0;
                g.area = '0;
                g.degen = 1'b1;
            end
            else
            begin
                g.nx = normal_comp(cr[0], len);
                g.ny = normal_comp(cr[1], len);
                g.nz = normal_comp(cr[2], len);
                g.area = len[AREA_W:1];
                g.degen = 1'b0;
            end
            g.fin = it.fin;
            return g;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic stim_row_t write_row(input int slot, input int x, input int y,
                                            input int z);
        stim_row_t r;
        begin
            r.it.cmd  = CMD_WRITE;
            r.it.slot = slot[INDEX_W-1:0];
            r.it.px   = x[COORD_W-1:0];
            r.it.py   = y[COORD_W-1:0];
            r.it.pz   = z[COORD_W-1:0];
            // Corner fields carry junk: the block must ignore them on a write
            r.it.ca   = INDEX_W'($urandom);
            r.it.cb   = INDEX_W'($urandom);
            r.it.cc   = INDEX_W'($urandom);
            r.it.fin  = 1'($urandom);
            r.known   = 1'b0;
            r.want    = '{default: '0};
            return r;
        end
    endfunction

    function automatic stim_row_t tri_row(input int a, input int b, input int c,
                                          input bit fin);
        stim_row_t r;
        begin
            r.it.cmd  = CMD_TRIANGLE;
            r.it.slot = INDEX_W'($urandom);
            r.it.px   = COORD_W'($urandom);
            r.it.py   = COORD_W'($urandom);
            r.it.pz   = COORD_W'($urandom);
            r.it.ca   = a[INDEX_W-1:0];
            r.it.cb   = b[INDEX_W-1:0];
            r.it.cc   = c[INDEX_W-1:0];
            r.it.fin  = fin;
            r.known   = 1'b0;
            r.want    = '{default: '0};
            return r;
        end
    endfunction

    // Triangle whose result is known by hand; all of these have zero area
    function automatic stim_row_t tri_row_known(input int a, input int b, input int c,
                                                input int mx, input int my, input int mz,
                                                input int ux, input int uy, input int uz,
                                                input bit degen);
        stim_row_t r;
        begin
            r = tri_row(a, b, c, 1'b0);
            r.known      = 1'b1;
            r.want.cen_x = mx[COORD_W-1:0];
            r.want.cen_y = my[COORD_W-1:0];
            r.want.cen_z = mz[COORD_W-1:0];
            r.want.nx    = ux[UNIT_W-1:0];
            r.want.ny    = uy[UNIT_W-1:0];
            r.want.nz    = uz[UNIT_W-1:0];
            r.want.area  = '0;
            r.want.degen = degen;
            r.want.fin   = 1'b0;
            return r;
        end
    endfunction

    function automatic int rand_coord();
        int pick;
        begin
            case ($urandom_range(0, 3))
                0, 1:    return int'($urandom_range(0, 1048575)) - 524288;
                2:       return int'($urandom_range(0, 4000)) - 2000;
                default:
                begin
                    pick = $urandom_range(0, 3);
                    return (pick == 0) ? -524288 : (pick == 1) ? 524287 : (pick == 2) ? 0 : -1;
                end
            endcase
        end
    endfunction

    function automatic int pick_written();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    // Present one item and hold it until taken; update the shadow store or
    // queue the expected geometry at the edge where it is accepted.
    task automatic send_item(input stim_row_t r);
        begin
            command      <= r.it.cmd;
            vertex_index <= r.it.slot;
            coord_x      <= r.it.px;
            coord_y      <= r.it.py;
            coord_z      <= r.it.pz;
            corner_a     <= r.it.ca;
            corner_b     <= r.it.cb;
            corner_c     <= r.it.cc;
            final_item   <= r.it.fin;
            in_valid     <= 1'b1;
            do
                @(posedge clk);
            while (in_stall);
            if (r.it.cmd == CMD_WRITE)
            begin
                shadow_x[r.it.slot] = r.it.px;
                shadow_y[r.it.slot] = r.it.py;
                shadow_z[r.it.slot] = r.it.pz;
                if (!slot_written[r.it.slot])
                begin
                    slot_written[r.it.slot] = 1'b1;
                    written_slots.push_back(r.it.slot);
                end
                write_count++;
            end
            else
            begin
                pending_geometry.push_back(r.known ? r.want : triangle_geometry(r.it));
                triangle_count++;
            end
        end
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        begin
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, in-order checking, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        geometry_t g;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
                $display("TEST FAILED");
                $finish;
            end

            if (out_valid && !out_stall)
            begin
                result_count++;
                if (pending_geometry.size() == 0)
                begin
                    report_mismatch("result with nothing pending, center_x",
                                    longint'(center_x), 0);
                end
                else
                begin
                    g = pending_geometry.pop_front();
                    if (g.degen)
                        degen_count++;
                    if (center_x !== g.cen_x)
                        report_mismatch("center_x", longint'(center_x), longint'(g.cen_x));
                    if (center_y !== g.cen_y)
                        report_mismatch("center_y", longint'(center_y), longint'(g.cen_y));
                    if (center_z !== g.cen_z)
                        report_mismatch("center_z", longint'(center_z), longint'(g.cen_z));
                    if (unit_x !== g.nx)
                        report_mismatch("unit_x", longint'(unit_x), longint'(g.nx));
                    if (unit_y !== g.ny)
                        report_mismatch("unit_y", longint'(unit_y), longint'(g.ny));
                    if (unit_z !== g.nz)
                        report_mismatch("unit_z", longint'(unit_z), longint'(g.nz));
                    if (area !== g.area)
                        report_mismatch("area", longint'(area), longint'(g.area));
                    if (degenerate !== g.degen)
                        report_mismatch("degenerate", longint'(degenerate), longint'(g.degen));
                    if (final_result !== g.fin)
                        report_mismatch("final_result", longint'(final_result),
                                        longint'(g.fin));
                end
            end
        end

        // Stall in random bursts; hold off entirely when quiet
        if (stall_left > 0)
        begin
            stall_left--;
            next_stall = 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 15) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            next_stall = 1'b1;
        end
        else
        begin
            next_stall = 1'b0;
        end
        out_stall <= next_stall;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t r;
        int        a;
        int        b;
        int        c;
        int        slot;

        // Extremes, unit axes, both signs of saturation and degenerate cases
        directed_rows.push_back(write_row(0, 0, 0, 0));
        directed_rows.push_back(write_row(1, 1, 0, 0));
        directed_rows.push_back(write_row(2, 0, 1, 0));
        directed_rows.push_back(write_row(4, 0, 0, 1));
        directed_rows.push_back(write_row(4095, -524288, -524288, -524288));
        directed_rows.push_back(write_row(4094, 524287, 524287, 524287));
        directed_rows.push_back(write_row(3, 524287, -524288, 0));
        directed_rows.push_back(write_row(2730, 12345, -6789, 333));
        directed_rows.push_back(write_row(1365, -1, 1, -1));
        directed_rows.push_back(tri_row_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        directed_rows.push_back(tri_row_known(0, 1, 2, 0, 0, 0, 0, 0, 32767, 1'b0));
        directed_rows.push_back(tri_row_known(0, 2, 1, 0, 0, 0, 0, 0, -32768, 1'b0));
        directed_rows.push_back(tri_row_known(4095, 4095, 4095,
                                              -524288, -524288, -524288, 0, 0, 0, 1'b1));
        directed_rows.push_back(tri_row_known(4094, 4094, 4094,
                                              524287, 524287, 524287, 0, 0, 0, 1'b1));
        directed_rows.push_back(tri_row(0, 4, 1, 1'b0));
        directed_rows.push_back(tri_row(0, 2, 4, 1'b0));
        directed_rows.push_back(tri_row(4095, 4094, 3, 1'b0));
        directed_rows.push_back(tri_row(3, 4094, 4095, 1'b1));
        directed_rows.push_back(tri_row(2730, 1365, 0, 1'b0));
        directed_rows.push_back(tri_row(1365, 4095, 2730, 1'b1));
        // Overwrite a corner and reuse it: the store must see the new value
        directed_rows.push_back(write_row(1, -524288, 524287, 524287));
        directed_rows.push_back(tri_row(1, 4094, 4095, 1'b0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i]);
            sender_gap();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= QUIET_FROM);
            if (n == DRAIN_AT)
            begin
                // Hold off until every pending triangle has come out
                in_valid <= 1'b0;
                while (pending_geometry.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                sender_gap();
            end

            if ($urandom_range(0, 99) < 55)
            begin
                if ($urandom_range(0, 3) == 0)
                    slot = pick_written();
                else
                    slot = $urandom_range(0, N_SLOTS - 1);
                r = write_row(slot, rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                a = pick_written();
                b = pick_written();
                c = pick_written();
                // Repeated corners force a degenerate triangle now and then
                case ($urandom_range(0, 9))
                    0:       b = a;
                    1:       c = b;
                    default: ;
                endcase
                r = tri_row(a, b, c, 1'($urandom));
            end
            send_item(r);
        end

        in_valid <= 1'b0;
        while (pending_geometry.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d vertex writes and %0d triangles, %0d results (%0d degenerate)",
                 write_count, triangle_count, result_count, degen_count);
        $display("%0d store slots written, %0d mismatches", written_slots.size(),
                 mismatch_count);
        if (mismatch_count == 0 && pending_geometry.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
